/* rtl/pdr_pkg.sv */
// Shared types and constants for the path deadband recorder.
// Payload structs, queue entry layout, register indexes and item kinds.
// No dependencies.
package pdr_pkg;

    localparam int COORD_BITS     = 24;
    localparam int TIME_BITS      = 32;
    localparam int PERIOD_BITS    = 32;
    localparam int MIN_DIST_BITS  = 24;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 1;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * COORD_BITS + 1;
    localparam int SUM_BITS  = SQ_BITS + 2;
    localparam int MDSQ_BITS = 2 * MIN_DIST_BITS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PERIOD_BITS-1:0]   SAMPLE_PERIOD_RESET = PERIOD_BITS'(1000);
    localparam logic [MIN_DIST_BITS-1:0] MIN_DISTANCE_RESET  = '0;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_PERIOD = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_DISTANCE  = 1'd1;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    localparam logic [1:0] KIND_FIRST = 2'd0;
    localparam logic [1:0] KIND_TEST  = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    typedef struct packed {
        logic                         mode;
        logic [TIME_BITS-1:0]         timestamp;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
    } pdr_in_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]         node_time;
        logic signed [COORD_BITS-1:0] node_x;
        logic signed [COORD_BITS-1:0] node_y;
        logic signed [COORD_BITS-1:0] node_z;
        logic                         end_of_run;
    } pdr_out_t;

    typedef struct packed {
        logic [1:0]                   kind;
        logic [TIME_BITS-1:0]         node_time;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic signed [DIFF_BITS-1:0]  dx;
        logic signed [DIFF_BITS-1:0]  dy;
        logic signed [DIFF_BITS-1:0]  dz;
    } pdr_entry_t;

    typedef struct packed {
        logic exec_valid;
        logic gap_phase;
        logic gap_pending;
    } pdr_back_status_t;

endpackage

/* rtl/path_deadband_recorder_unit.sv */
// Path deadband recorder: top level with configuration registers.
// Depends on pdr_pkg, pdr_front, pdr_queue, pdr_back.
//
// Takes one item per clock while the four-entry queue between the front end
// and the back end has room; in_ready does not depend on out_ready. An item
// passes through the queue write and then the squaring register before its
// first result appears; the add and compare of the distance test sit after
// that register. An item that releases a gap node and its own sample holds
// the output for two transactions, so the sustained rate is one item per
// clock while out_ready is high, except for those, which take an extra
// output transaction. Samples that fail the period or distance test and
// flushes with no gap pending produce no result; reset needs no clearing pass.
module path_deadband_recorder_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  pdr_pkg::pdr_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output pdr_pkg::pdr_out_t                  out_data,
    input  logic                               cfg_we,
    input  logic [pdr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pdr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import pdr_pkg::*;

    logic [PERIOD_BITS-1:0]   sample_period_reg;
    logic [MIN_DIST_BITS-1:0] min_distance_reg;

    logic             push;
    pdr_entry_t       push_entry;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    pdr_entry_t       head_entry;
    pdr_back_status_t back_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= SAMPLE_PERIOD_RESET;
            min_distance_reg  <= MIN_DISTANCE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_PERIOD: sample_period_reg <= PERIOD_BITS'(cfg_data);
                REG_MIN_DISTANCE:  min_distance_reg  <= cfg_data[MIN_DIST_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    pdr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .sample_period (sample_period_reg),
        .q_full        (q_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    pdr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_full     (q_full),
        .q_valid    (q_valid),
        .head_entry (head_entry)
    );

    pdr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .min_distance (min_distance_reg),
        .q_valid      (q_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .status       (back_status)
    );

    // a gap node keeps the output valid until its sample has followed
    a_gap_then_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.end_of_run |=> out_valid)
        else $error("gap node not followed by sample");

    a_no_output_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !back_status.exec_valid |-> !out_valid)
        else $error("output valid with empty execute stage");

    a_phase_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.gap_phase |-> out_valid && back_status.gap_pending)
        else $error("second-result phase without pending output");

endmodule

/* rtl/pdr_front.sv */
// Front end: accepts items, tracks start time and kept node, classifies.
// Pushes first samples, period-qualified samples and flushes to the queue.
// Depends on pdr_pkg.
module pdr_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pdr_pkg::pdr_in_t                    in_data,
    input  logic [pdr_pkg::PERIOD_BITS-1:0]     sample_period,
    input  logic                                q_full,
    output logic                                push,
    output pdr_pkg::pdr_entry_t                 push_entry
);
    import pdr_pkg::*;

    logic                  started_reg, started_next;
    logic [TIME_BITS-1:0]  start_time_reg, start_time_next;
    logic [TIME_BITS-1:0]  kept_time_reg, kept_time_next;
    logic [COORD_BITS-1:0] kept_x_reg, kept_x_next;
    logic [COORD_BITS-1:0] kept_y_reg, kept_y_next;
    logic [COORD_BITS-1:0] kept_z_reg, kept_z_next;

    logic                 accept;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] delta;
    logic                 period_hit;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign elapsed    = in_data.timestamp - start_time_reg;
    assign delta      = elapsed - kept_time_reg;
    assign period_hit = PERIOD_BITS'(delta) > sample_period;

    always_comb
    begin
        started_next    = started_reg;
        start_time_next = start_time_reg;
        kept_time_next  = kept_time_reg;
        kept_x_next     = kept_x_reg;
        kept_y_next     = kept_y_reg;
        kept_z_next     = kept_z_reg;
        push            = 1'b0;

        push_entry.kind      = KIND_TEST;
        push_entry.node_time = elapsed;
        push_entry.x         = in_data.pos_x;
        push_entry.y         = in_data.pos_y;
        push_entry.z         = in_data.pos_z;
        // exact differences, sign extended by one bit
        push_entry.dx = {in_data.pos_x[COORD_BITS-1], in_data.pos_x}
                      - {kept_x_reg[COORD_BITS-1], kept_x_reg};
        push_entry.dy = {in_data.pos_y[COORD_BITS-1], in_data.pos_y}
                      - {kept_y_reg[COORD_BITS-1], kept_y_reg};
        push_entry.dz = {in_data.pos_z[COORD_BITS-1], in_data.pos_z}
                      - {kept_z_reg[COORD_BITS-1], kept_z_reg};

        if (accept)
        begin
            if (in_data.mode == MODE_FLUSH)
            begin
                push            = 1'b1;
                push_entry.kind = KIND_FLUSH;
            end
            else if (!started_reg)
            begin
                push                 = 1'b1;
                push_entry.kind      = KIND_FIRST;
                push_entry.node_time = '0;
                started_next         = 1'b1;
                start_time_next      = in_data.timestamp;
                kept_time_next       = '0;
                kept_x_next          = in_data.pos_x;
                kept_y_next          = in_data.pos_y;
                kept_z_next          = in_data.pos_z;
            end
            else if (period_hit)
            begin
                push            = 1'b1;
                push_entry.kind = KIND_TEST;
                kept_time_next  = elapsed;
                kept_x_next     = in_data.pos_x;
                kept_y_next     = in_data.pos_y;
                kept_z_next     = in_data.pos_z;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg    <= 1'b0;
            start_time_reg <= '0;
            kept_time_reg  <= '0;
            kept_x_reg     <= '0;
            kept_y_reg     <= '0;
            kept_z_reg     <= '0;
        end
        else
        begin
            started_reg    <= started_next;
            start_time_reg <= start_time_next;
            kept_time_reg  <= kept_time_next;
            kept_x_reg     <= kept_x_next;
            kept_y_reg     <= kept_y_next;
            kept_z_reg     <= kept_z_next;
        end
    end

endmodule

/* rtl/pdr_queue.sv */
// Short FIFO between front end and back end.
// Register file of QUEUE_DEPTH entries with read and write pointers.
// Depends on pdr_pkg.
module pdr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pdr_pkg::pdr_entry_t push_entry,
    input  logic                pop,
    output logic                q_full,
    output logic                q_valid,
    output pdr_pkg::pdr_entry_t head_entry
);
    import pdr_pkg::*;

    pdr_entry_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    assign q_full     = count_reg == QCNT_BITS'(QUEUE_DEPTH);
    assign q_valid    = count_reg != '0;
    assign head_entry = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/pdr_back.sv */
// Back end: squares the differences, tests distance, tracks the gap node
// and emits zero, one or two result transactions per queued entry.
// Depends on pdr_pkg.
module pdr_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pdr_pkg::MIN_DIST_BITS-1:0] min_distance,
    input  logic                              q_valid,
    input  pdr_pkg::pdr_entry_t               head_entry,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output pdr_pkg::pdr_out_t                 out_data,
    output pdr_pkg::pdr_back_status_t         status
);
    import pdr_pkg::*;

    // execute register: entry plus registered squares
    logic                  x_valid_reg, x_valid_next;
    logic [1:0]            x_kind_reg;
    logic [TIME_BITS-1:0]  x_time_reg;
    logic [COORD_BITS-1:0] x_x_reg, x_y_reg, x_z_reg;
    logic [SQ_BITS-1:0]    x_sqx_reg, x_sqy_reg, x_sqz_reg;
    logic [MDSQ_BITS-1:0]  x_mdsq_reg;

    logic                  phase_reg, phase_next;
    logic                  gap_reg, gap_next;
    logic [TIME_BITS-1:0]  gap_time_reg;
    logic [COORD_BITS-1:0] gap_x_reg, gap_y_reg, gap_z_reg;

    logic signed [2*DIFF_BITS-1:0] prod_x, prod_y, prod_z;
    logic [MDSQ_BITS-1:0]          prod_md;
    logic [SUM_BITS-1:0]           dist_sum;
    logic                          far;
    logic                          emit_gap;
    logic                          end_run;
    logic                          done;
    logic                          load;
    logic                          node_keep;

    assign prod_x  = head_entry.dx * head_entry.dx;
    assign prod_y  = head_entry.dy * head_entry.dy;
    assign prod_z  = head_entry.dz * head_entry.dz;
    assign prod_md = min_distance * min_distance;

    assign dist_sum = SUM_BITS'(x_sqx_reg) + SUM_BITS'(x_sqy_reg) + SUM_BITS'(x_sqz_reg);
    assign far      = dist_sum >= SUM_BITS'(x_mdsq_reg);

    always_comb
    begin
        out_valid  = 1'b0;
        emit_gap   = 1'b0;
        end_run    = 1'b0;
        done       = 1'b0;
        node_keep  = 1'b0;
        phase_next = phase_reg;
        gap_next   = gap_reg;
        if (x_valid_reg)
        begin
            case (x_kind_reg)
                KIND_FIRST:
                begin
                    out_valid = 1'b1;
                    end_run   = 1'b1;
                    done      = out_ready;
                    node_keep = out_ready;
                end
                KIND_FLUSH:
                begin
                    if (gap_reg)
                    begin
                        out_valid = 1'b1;
                        emit_gap  = 1'b1;
                        end_run   = 1'b1;
                        done      = out_ready;
                        if (out_ready)
                        begin
                            gap_next = 1'b0;
                        end
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                KIND_TEST:
                begin
                    if (!far)
                    begin
                        done      = 1'b1;
                        node_keep = 1'b1;
                        gap_next  = 1'b1;
                    end
                    else if (gap_reg && !phase_reg)
                    begin
                        // pending gap node goes out ahead of the sample
                        out_valid = 1'b1;
                        emit_gap  = 1'b1;
                        if (out_ready)
                        begin
                            phase_next = 1'b1;
                        end
                    end
                    else
                    begin
                        out_valid = 1'b1;
                        end_run   = 1'b1;
                        done      = out_ready;
                        node_keep = out_ready;
                        if (out_ready)
                        begin
                            gap_next   = 1'b0;
                            phase_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end
    end

    assign load         = q_valid && (!x_valid_reg || done);
    assign pop          = load;
    assign x_valid_next = load || (x_valid_reg && !done);

    always_comb
    begin
        out_data.node_time  = emit_gap ? gap_time_reg : x_time_reg;
        out_data.node_x     = emit_gap ? gap_x_reg : x_x_reg;
        out_data.node_y     = emit_gap ? gap_y_reg : x_y_reg;
        out_data.node_z     = emit_gap ? gap_z_reg : x_z_reg;
        out_data.end_of_run = end_run;
    end

    assign status.exec_valid  = x_valid_reg;
    assign status.gap_phase   = phase_reg;
    assign status.gap_pending = gap_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_kind_reg <= head_entry.kind;
            x_time_reg <= head_entry.node_time;
            x_x_reg    <= head_entry.x;
            x_y_reg    <= head_entry.y;
            x_z_reg    <= head_entry.z;
            x_sqx_reg  <= SQ_BITS'(prod_x);
            x_sqy_reg  <= SQ_BITS'(prod_y);
            x_sqz_reg  <= SQ_BITS'(prod_z);
            x_mdsq_reg <= prod_md;
        end
        if (node_keep)
        begin
            gap_time_reg <= x_time_reg;
            gap_x_reg    <= x_x_reg;
            gap_y_reg    <= x_y_reg;
            gap_z_reg    <= x_z_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
            gap_reg     <= 1'b0;
        end
        else
        begin
            x_valid_reg <= x_valid_next;
            phase_reg   <= phase_next;
            gap_reg     <= gap_next;
        end
    end

endmodule
